### rtl/gpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpe_pkg
// shared types and constants of the gpio port block with edge interrupts
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam int DATA_W         = 32;
    localparam int SEL_W          = 4;
    localparam int PORT_IDX_W     = 3;
    localparam int NUM_PORTS_DEF  = 5;
    localparam int PORT_WIDTH_DEF = 32;
    localparam int IRQ_SLOTS      = 2;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

    localparam logic [PORT_IDX_W-1:0] PORT_IRQ_A = 3'd0;
    localparam logic [PORT_IDX_W-1:0] PORT_IRQ_B = 3'd2;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_DIR       = 4'd0,
        SEL_PIN       = 4'd1,
        SEL_SET       = 4'd2,
        SEL_CLEAR     = 4'd3,
        SEL_RISE_EN   = 4'd4,
        SEL_FALL_EN   = 4'd5,
        SEL_RISE_STAT = 4'd6,
        SEL_FALL_STAT = 4'd7,
        SEL_INT_CLEAR = 4'd8,
        SEL_OVERALL   = 4'd9
    } reg_sel_t;

    typedef struct packed {
        cmd_t                    cmd;
        reg_sel_t                reg_select;
        logic [PORT_IDX_W-1:0]   port;
        logic [DATA_W-1:0]       write_data;
        logic [DATA_W-1:0]       pin_levels;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic [DATA_W-1:0] drive_levels;
        logic              access_error;
    } result_t;

endpackage

`default_nettype wire

### rtl/gpe_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpe_core
// port register file, edge detection and result logic for one transaction
// ----------------------------------------------------------------------------
module gpe_core #(
    parameter int NUM_PORTS  = gpe_pkg::NUM_PORTS_DEF,
    parameter int PORT_WIDTH = gpe_pkg::PORT_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire gpe_pkg::item_t  item,
    output gpe_pkg::result_t     result
);
    import gpe_pkg::*;

    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    typedef logic [PORT_WIDTH-1:0] pins_t;

    pins_t dir_reg       [NUM_PORTS];
    pins_t dir_next      [NUM_PORTS];
    pins_t latch_reg     [NUM_PORTS];
    pins_t latch_next    [NUM_PORTS];
    pins_t prev_reg      [NUM_PORTS];
    pins_t prev_next     [NUM_PORTS];
    pins_t rise_en_reg   [IRQ_SLOTS];
    pins_t rise_en_next  [IRQ_SLOTS];
    pins_t fall_en_reg   [IRQ_SLOTS];
    pins_t fall_en_next  [IRQ_SLOTS];
    pins_t rise_stat_reg [IRQ_SLOTS];
    pins_t rise_stat_next[IRQ_SLOTS];
    pins_t fall_stat_reg [IRQ_SLOTS];
    pins_t fall_stat_next[IRQ_SLOTS];

    logic              valid;
    logic              bus;
    logic              is_read;
    logic              is_int_sel;
    logic              slot_ok;
    logic              slot;
    logic [PIDX_W-1:0] p;
    pins_t             wd;
    pins_t             lv;
    pins_t             rd;
    pins_t             overall;
    pins_t             drive;
    logic              err;
    logic              irq;

    assign valid      = {1'b0, item.port} < (PORT_IDX_W + 1)'(NUM_PORTS);
    assign p          = valid ? item.port[PIDX_W-1:0] : '0;
    assign bus        = (item.cmd == CMD_READ) || (item.cmd == CMD_WRITE);
    assign is_read    = (item.cmd == CMD_READ);
    assign is_int_sel = (item.reg_select >= SEL_RISE_EN) && (item.reg_select <= SEL_INT_CLEAR);
    assign slot_ok    = valid && ((item.port == PORT_IRQ_A) || (item.port == PORT_IRQ_B));
    assign slot       = (item.port == PORT_IRQ_B);
    assign wd         = item.write_data[PORT_WIDTH-1:0];
    assign lv         = item.pin_levels[PORT_WIDTH-1:0];

    always_comb
    begin
        overall    = '0;
        overall[0] = |(rise_stat_reg[0] | fall_stat_reg[0]);
        overall[2] = |(rise_stat_reg[1] | fall_stat_reg[1]);
    end

    // next state and read data of the transaction
    always_comb
    begin
        dir_next       = dir_reg;
        latch_next     = latch_reg;
        prev_next      = prev_reg;
        rise_en_next   = rise_en_reg;
        fall_en_next   = fall_en_reg;
        rise_stat_next = rise_stat_reg;
        fall_stat_next = fall_stat_reg;
        rd             = '0;
        err            = 1'b0;

        if (bus && valid && is_int_sel && !slot_ok)
        begin
            err = 1'b1;
        end
        else if (bus && valid)
        begin
            unique case (item.reg_select)
                SEL_DIR:
                begin
                    if (is_read) rd = dir_reg[p];
                    else dir_next[p] = wd;
                end
                SEL_PIN:
                begin
                    if (is_read) rd = (prev_reg[p] & ~dir_reg[p]) | (latch_reg[p] & dir_reg[p]);
                    else latch_next[p] = wd;
                end
                SEL_SET:
                begin
                    if (is_read) rd = latch_reg[p];
                    else latch_next[p] = latch_reg[p] | wd;
                end
                SEL_CLEAR:
                begin
                    if (!is_read) latch_next[p] = latch_reg[p] & ~wd;
                end
                SEL_RISE_EN:
                begin
                    if (is_read) rd = rise_en_reg[slot];
                    else rise_en_next[slot] = wd;
                end
                SEL_FALL_EN:
                begin
                    if (is_read) rd = fall_en_reg[slot];
                    else fall_en_next[slot] = wd;
                end
                SEL_RISE_STAT:
                begin
                    if (is_read) rd = rise_stat_reg[slot];
                end
                SEL_FALL_STAT:
                begin
                    if (is_read) rd = fall_stat_reg[slot];
                end
                SEL_INT_CLEAR:
                begin
                    if (!is_read)
                    begin
                        rise_stat_next[slot] = rise_stat_reg[slot] & ~wd;
                        fall_stat_next[slot] = fall_stat_reg[slot] & ~wd;
                    end
                end
                SEL_OVERALL:
                begin
                    if (is_read) rd = overall;
                end
                default:
                begin
                    rd = '0;
                end
            endcase
        end
        else if (bus && (item.reg_select == SEL_OVERALL))
        begin
            // overall status ignores the port field
            if (is_read) rd = overall;
        end
        else if (valid && (item.cmd == CMD_SAMPLE))
        begin
            if (slot_ok)
            begin
                rise_stat_next[slot] = rise_stat_reg[slot] |
                                       (lv & ~prev_reg[p] & rise_en_reg[slot]);
                fall_stat_next[slot] = fall_stat_reg[slot] |
                                       (~lv & prev_reg[p] & fall_en_reg[slot]);
            end
            prev_next[p] = lv;
        end
    end

    assign drive = valid ? (latch_next[p] & dir_next[p]) : '0;
    assign irq   = |(rise_stat_next[0] | fall_stat_next[0] |
                     rise_stat_next[1] | fall_stat_next[1]);

    assign result.read_data    = DATA_W'(rd);
    assign result.irq          = irq;
    assign result.drive_levels = DATA_W'(drive);
    assign result.access_error = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                dir_reg[i]   <= '0;
                latch_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
            for (int i = 0; i < IRQ_SLOTS; i++)
            begin
                rise_en_reg[i]   <= '0;
                fall_en_reg[i]   <= '0;
                rise_stat_reg[i] <= '0;
                fall_stat_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            dir_reg       <= dir_next;
            latch_reg     <= latch_next;
            prev_reg      <= prev_next;
            rise_en_reg   <= rise_en_next;
            fall_en_reg   <= fall_en_next;
            rise_stat_reg <= rise_stat_next;
            fall_stat_reg <= fall_stat_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gpio_port_edge_interrupt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_port_edge_interrupt
// gpio ports with direction, output latch and edge interrupts on ports 0 and 2
// ----------------------------------------------------------------------------
// One transaction (bus read, bus write or pin sample) enters per clock and
// gives one result: it is held in the input register, where the register
// file is read and updated, and then in the result register. Throughput is
// one transaction per clock while the result side takes results; while a
// finished result waits, the input register takes one further transaction
// and the input then stalls until the result is taken.
// irq in each result reflects status after that transaction; access_error
// flags interrupt registers addressed on an in-range port without interrupts.
module gpio_port_edge_interrupt #(
    parameter int NUM_PORTS  = gpe_pkg::NUM_PORTS_DEF,
    parameter int PORT_WIDTH = gpe_pkg::PORT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // reg_select[3:0], port[6:4], write_data[38:7], pin_levels[70:39]
    input  wire logic [gpe_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [gpe_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // read_data[31:0], irq[32], drive_levels[64:33]
    output logic [gpe_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // access_error[0]
    output logic [gpe_pkg::M_TUSER_W-1:0]      m_axis_tuser
);
    import gpe_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    item_t   in_item;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;
    result_t result;
    logic    advance;
    logic    s_fire;

    assign in_item.cmd        = cmd_t'(s_axis_tuser);
    assign in_item.reg_select = reg_sel_t'(s_axis_tdata[3:0]);
    assign in_item.port       = s_axis_tdata[6:4];
    assign in_item.write_data = s_axis_tdata[38:7];
    assign in_item.pin_levels = s_axis_tdata[70:39];

    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign s_fire         = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    gpe_core #(
        .NUM_PORTS  (NUM_PORTS),
        .PORT_WIDTH (PORT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_result_reg.drive_levels,
                                       out_result_reg.irq,
                                       out_result_reg.read_data});
    assign m_axis_tuser  = out_result_reg.access_error;

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0)
        else $error("access error with non-zero read data");

    a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled without a held transaction");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("processed transaction lost before result register");

    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("held transaction changed while stalled");

endmodule

`default_nettype wire

### bench/tb_gpio_port_edge_interrupt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gpio_port_edge_interrupt
// self-checking bench for the gpio port block with edge interrupts
// ----------------------------------------------------------------------------
// Drives bus reads, bus writes and pin samples into the slave stream, with
// random gaps on the sending side and random stalls on the result side. A
// scoreboard keeps its own copy of the port registers and edge status, works
// out the result of every accepted transaction and checks each result field
// by field in order. A directed opening covers the register map, the edge
// logic, the error and out-of-range cases; random traffic follows.
// ----------------------------------------------------------------------------
import gpe_pkg::*;

class gpio_edge_scoreboard;

    logic [DATA_W-1:0] dir_bits   [NUM_PORTS_DEF];
    logic [DATA_W-1:0] latch_bits [NUM_PORTS_DEF];
    logic [DATA_W-1:0] sampled_lv [NUM_PORTS_DEF];
    logic [DATA_W-1:0] rise_en    [IRQ_SLOTS];
    logic [DATA_W-1:0] fall_en    [IRQ_SLOTS];
    logic [DATA_W-1:0] rise_st    [IRQ_SLOTS];
    logic [DATA_W-1:0] fall_st    [IRQ_SLOTS];
    result_t           expected_results[$];
    int                mismatch_count;

    function new();
        for (int i = 0; i < NUM_PORTS_DEF; i++)
        begin
            dir_bits[i]   = '0;
            latch_bits[i] = '0;
            sampled_lv[i] = '0;
        end
        for (int i = 0; i < IRQ_SLOTS; i++)
        begin
            rise_en[i] = '0;
            fall_en[i] = '0;
            rise_st[i] = '0;
            fall_st[i] = '0;
        end
        mismatch_count = 0;
    endfunction

    function logic [DATA_W-1:0] overall_word();
        logic [DATA_W-1:0] v;
        v = '0;
        v[0] = |(rise_st[0] | fall_st[0]);
        v[2] = |(rise_st[1] | fall_st[1]);
        return v;
    endfunction

    function void note_transaction(item_t it);
        result_t           exp;
        int                slot;
        int                p;
        bit                in_range;
        bit                wr;
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] lv;
        logic [DATA_W-1:0] prev;
        exp      = '0;
        in_range = it.port < NUM_PORTS_DEF;
        p        = in_range ? int'(it.port) : 0;
        slot     = (it.port == PORT_IRQ_A) ? 0 : (it.port == PORT_IRQ_B) ? 1 : -1;
        wd       = it.write_data;
        lv       = it.pin_levels;
        wr       = (it.cmd == CMD_WRITE);
        if (in_range && (it.cmd == CMD_READ || it.cmd == CMD_WRITE))
        begin
            if (it.reg_select >= SEL_RISE_EN && it.reg_select <= SEL_INT_CLEAR && slot < 0)
            begin
                exp.access_error = 1'b1;
            end
            else
            begin
                case (it.reg_select)
                    SEL_DIR:
                        if (wr) dir_bits[p] = wd; else exp.read_data = dir_bits[p];
                    SEL_PIN:
                        if (wr) latch_bits[p] = wd;
                        else exp.read_data = (sampled_lv[p] & ~dir_bits[p]) |
                                             (latch_bits[p] & dir_bits[p]);
                    SEL_SET:
                        if (wr) latch_bits[p] |= wd; else exp.read_data = latch_bits[p];
                    SEL_CLEAR:
                        if (wr) latch_bits[p] &= ~wd;
                    SEL_RISE_EN:
                        if (wr) rise_en[slot] = wd; else exp.read_data = rise_en[slot];
                    SEL_FALL_EN:
                        if (wr) fall_en[slot] = wd; else exp.read_data = fall_en[slot];
                    SEL_RISE_STAT:
                        if (!wr) exp.read_data = rise_st[slot];
                    SEL_FALL_STAT:
                        if (!wr) exp.read_data = fall_st[slot];
                    SEL_INT_CLEAR:
                        if (wr)
                        begin
                            rise_st[slot] &= ~wd;
                            fall_st[slot] &= ~wd;
                        end
                    SEL_OVERALL:
                        if (!wr) exp.read_data = overall_word();
                    default: ;
                endcase
            end
        end
        else if (!in_range && it.cmd == CMD_READ && it.reg_select == SEL_OVERALL)
        begin
            exp.read_data = overall_word();
        end
        else if (in_range && it.cmd == CMD_SAMPLE)
        begin
            prev = sampled_lv[p];
            if (slot >= 0)
            begin
                rise_st[slot] |= lv & ~prev & rise_en[slot];
                fall_st[slot] |= ~lv & prev & fall_en[slot];
            end
            sampled_lv[p] = lv;
        end
        exp.irq = |overall_word();
        if (in_range)
            exp.drive_levels = latch_bits[p] & dir_bits[p];
        expected_results.push_back(exp);
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] exp_v,
                              logic [DATA_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t %s: expected %h, got %h", $time, name, exp_v, got_v);
        end
    endfunction

    function void check_result(result_t got);
        result_t exp;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t result %h with no transaction pending", $time, got);
            return;
        end
        exp = expected_results.pop_front();
        check_field("read_data", exp.read_data, got.read_data);
        check_field("irq", DATA_W'(exp.irq), DATA_W'(got.irq));
        check_field("drive_levels", exp.drive_levels, got.drive_levels);
        check_field("access_error", DATA_W'(exp.access_error), DATA_W'(got.access_error));
    endfunction

endclass

module tb_gpio_port_edge_interrupt;

    localparam real CLK_PERIOD     = 8.0;
    localparam int  RANDOM_ITEMS   = 400;
    localparam int  DRAIN_CYCLES   = 16;
    localparam int  WATCHDOG_LIMIT = 1000;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire logic            s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    wire logic            m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire [M_TDATA_W-1:0]  m_axis_tdata;
    wire [M_TUSER_W-1:0]  m_axis_tuser;

    gpio_edge_scoreboard sb = new();
    int                  idle_cycles  = 0;
    int                  send_left    = 0;
    bit                  send_calm    = 1'b0;
    int                  stall_left   = 0;
    bit                  stall_calm   = 1'b0;

    gpio_port_edge_interrupt u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // stretches of back-to-back traffic and stretches of random waits come in random order
    function automatic int draw_wait(inout int stretch_left, inout bit calm);
        if (stretch_left == 0)
        begin
            calm         = ($urandom_range(0, 2) == 0);
            stretch_left = $urandom_range(8, 40);
        end
        stretch_left--;
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic item_t make_item(cmd_t c, reg_sel_t s, logic [PORT_IDX_W-1:0] p,
                                        logic [DATA_W-1:0] wd, logic [DATA_W-1:0] lv);
        item_t it;
        it.cmd        = c;
        it.reg_select = s;
        it.port       = p;
        it.write_data = wd;
        it.pin_levels = lv;
        return it;
    endfunction

    function automatic item_t random_item();
        int                    r;
        logic [1:0]            c;
        logic [SEL_W-1:0]      s;
        logic [PORT_IDX_W-1:0] p;
        logic [DATA_W-1:0]     wd;
        logic [DATA_W-1:0]     lv;
        r  = $urandom_range(0, 99);
        wd = $urandom;
        lv = $urandom;
        if (r < 8)
        begin
            c = 2'($urandom);
            s = SEL_W'($urandom);
            p = PORT_IDX_W'($urandom);
        end
        else
        begin
            c = (r < 45) ? CMD_SAMPLE : (r < 75) ? CMD_WRITE : CMD_READ;
            if ($urandom_range(0, 4) < 3)
                p = $urandom_range(0, 1) ? PORT_IRQ_A : PORT_IRQ_B;
            else
                p = PORT_IDX_W'($urandom_range(0, NUM_PORTS_DEF - 1));
            s = SEL_W'($urandom_range(SEL_DIR, SEL_OVERALL));
            case ($urandom_range(0, 3))
                0:       wd = '1;
                1:       wd = $urandom & $urandom;
                default: ;
            endcase
            if ($urandom_range(0, 2) == 0)
                lv = $urandom & $urandom & $urandom;
        end
        return make_item(cmd_t'(c), reg_sel_t'(s), p, wd, lv);
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = draw_wait(send_left, send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        // pin_levels, write_data, port, reg_select from the top down
        s_axis_tdata  <= {1'b0, it.pin_levels, it.write_data, it.port, it.reg_select};
        s_axis_tuser  <= it.cmd;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_transaction(it);
    endtask

    initial
    begin
        int stall;
        result_t got;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(stall_left, stall_calm);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            got.read_data    = m_axis_tdata[31:0];
            got.irq          = m_axis_tdata[32];
            got.drive_levels = m_axis_tdata[64:33];
            got.access_error = m_axis_tuser[0];
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register map on a port without interrupts
        send_item(make_item(CMD_READ,  SEL_OVERALL,   3'd7, '0, '0));
        send_item(make_item(CMD_WRITE, SEL_DIR,       3'd1, '1, '0));
        send_item(make_item(CMD_WRITE, SEL_PIN,       3'd1, 32'hA5A5_A5A5, '1));
        send_item(make_item(CMD_WRITE, SEL_SET,       3'd1, 32'h0000_FFFF, '0));
        send_item(make_item(CMD_WRITE, SEL_CLEAR,     3'd1, 32'h0F0F_0F0F, '0));
        send_item(make_item(CMD_READ,  SEL_PIN,       3'd1, '1, '1));
        send_item(make_item(CMD_READ,  SEL_SET,       3'd1, '0, '0));
        send_item(make_item(CMD_READ,  SEL_CLEAR,     3'd1, '0, '0));
        send_item(make_item(CMD_READ,  SEL_DIR,       3'd1, '0, '0));
        // edges on both interrupt ports
        send_item(make_item(CMD_WRITE, SEL_RISE_EN,   3'd0, '1, '0));
        send_item(make_item(CMD_WRITE, SEL_FALL_EN,   3'd0, '1, '0));
        send_item(make_item(CMD_SAMPLE, SEL_DIR,      3'd0, '0, '1));
        send_item(make_item(CMD_SAMPLE, SEL_OVERALL,  3'd0, '1, '0));
        send_item(make_item(CMD_READ,  SEL_RISE_STAT, 3'd0, '0, '0));
        send_item(make_item(CMD_READ,  SEL_FALL_STAT, 3'd0, '0, '0));
        send_item(make_item(CMD_WRITE, SEL_RISE_STAT, 3'd0, '0, '0));
        send_item(make_item(CMD_WRITE, SEL_RISE_EN,   3'd2, 32'h5555_5555, '0));
        send_item(make_item(CMD_SAMPLE, SEL_PIN,      3'd2, '0, 32'hFFFF_0000));
        send_item(make_item(CMD_READ,  SEL_OVERALL,   3'd3, '0, '0));
        send_item(make_item(CMD_WRITE, SEL_OVERALL,   3'd2, '1, '0));
        send_item(make_item(CMD_WRITE, SEL_INT_CLEAR, 3'd0, '1, '0));
        send_item(make_item(CMD_READ,  SEL_INT_CLEAR, 3'd2, '1, '0));
        send_item(make_item(CMD_READ,  SEL_PIN,       3'd0, '0, '0));
        // errors, out-of-range ports, unused selectors, no-op
        send_item(make_item(CMD_WRITE, SEL_RISE_EN,   3'd3, '1, '0));
        send_item(make_item(CMD_READ,  SEL_FALL_STAT, 3'd4, '0, '0));
        send_item(make_item(CMD_WRITE, SEL_DIR,       3'd6, '1, '1));
        send_item(make_item(CMD_SAMPLE, SEL_DIR,      3'd5, '0, '1));
        send_item(make_item(CMD_READ,  reg_sel_t'(4'hC), 3'd1, '0, '0));
        send_item(make_item(CMD_WRITE, reg_sel_t'(4'hF), 3'd1, '1, '0));
        send_item(make_item(CMD_NOP,   SEL_DIR,       3'd1, '1, '1));

        repeat (RANDOM_ITEMS) send_item(random_item());
        s_axis_tvalid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
